FILE: rtl/alignment_hit_filter_core_macros.svh
// alignment_hit_filter_core_macros.svh: assertion macros for the hit filter
// expects signals clk and arst_n in the module that uses them
`ifndef ALIGNMENT_HIT_FILTER_CORE_MACROS_SVH
`define ALIGNMENT_HIT_FILTER_CORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define AHF_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define AHF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define AHF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ahf_pkg.sv
// ahf_pkg: widths, codes, word types and helpers of the alignment hit filter
// no dependencies
`default_nettype none

package ahf_pkg;

	localparam int CB = 20;            // coordinate bits
	localparam int WB = CB + 1;        // overhang and overlap bits
	localparam int NB = CB + 7;        // span times one hundred
	localparam int DB = CB + 8;        // divisor shifted by eight
	localparam int QB = 9;             // quotient bits, top bit flags saturation
	localparam int IB = 7;             // identity bits
	localparam int SB = 20;            // score bits
	localparam int CW = ((WB > SB) ? WB : SB) + 1;  // signed compare width
	localparam int AW = 5;             // apb address bits

	localparam logic [NB-1:0] HUNDRED = NB'(100);
	localparam logic [WB-1:0] W_ONE = WB'(1);

	localparam logic [1:0] ST_PASS    = 2'd0;
	localparam logic [1:0] ST_REJECT  = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef enum logic [2:0] {
		REG_MIN_IDENTITY,
		REG_MIN_COVERAGE,
		REG_MIN_OVERLAP,
		REG_MAX_OVERHANG,
		REG_MIN_SCORE
	} reg_idx_t;

	typedef struct packed {
		logic [CB-1:0] query_length;
		logic [CB-1:0] query_start;
		logic [CB-1:0] query_end;
		logic [CB-1:0] subject_length;
		logic [CB-1:0] subject_start;
		logic [CB-1:0] subject_end;
		logic [IB-1:0] identity;
		logic [SB-1:0] score;
	} hit_t;

	// hit with ordered ends
	typedef struct packed {
		logic          bad;
		logic          minus;
		logic [CB-1:0] qlen;
		logic [CB-1:0] slen;
		logic [CB-1:0] q_lo;
		logic [CB-1:0] q_hi;
		logic [CB-1:0] s_lo;
		logic [CB-1:0] s_hi;
		logic [CB-1:0] span_q;
		logic [CB-1:0] span_s;
		logic [IB-1:0] ident;
		logic [SB-1:0] score;
	} ord_t;

	// word travelling down the divider cells
	typedef struct packed {
		logic                 bad;
		logic                 minus;
		logic signed [WB-1:0] left;
		logic signed [WB-1:0] right;
		logic [WB-1:0]        overlap;
		logic [IB-1:0]        ident;
		logic [SB-1:0]        score;
		logic [NB-1:0]        rem;
		logic [DB-1:0]        dsh;
		logic [QB-1:0]        quo;
	} cell_t;

	function automatic logic signed [WB-1:0] smin(input logic signed [WB-1:0] a,
		input logic signed [WB-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/alignment_hit_filter_core.sv
// alignment_hit_filter_core: top level, config registers, divider chain, verdict
// depends on ahf_pkg, ahf_prep, ahf_div_cell and the assertion macro header
//
// Usage: one alignment hit enters on the input channel (in_valid/in_stall) as
// eight fields; one result word leaves on the output channel
// (out_valid/out_stall) for every hit, in order. The thresholds sit behind an
// APB port, registers at byte addresses 0, 4, 8, 12 and 16; write them only
// while no hit is in flight. pready is always high.
// Pipeline: a hit passes two front stages, nine division cells (one quotient
// bit each, the first flagging coverage of 256 or more) and the output
// register before its result shows on out_valid.
// Throughput: one hit per cycle while out_stall is low, set by the
// single-step division cells.
// Stall: every stage holds its word while the stage after it is full and held;
// empty stages keep filling, so in_stall rises only once all twelve stages
// hold a word and out_stall is high.
// Reset: all stages empty, thresholds return to identity 0, coverage 0,
// overlap 20, overhang 100000, score 0.
`default_nettype none
`include "alignment_hit_filter_core_macros.svh"

module alignment_hit_filter_core import ahf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AW-1:0]        paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CB-1:0]        query_length,
	input  logic [CB-1:0]        query_start,
	input  logic [CB-1:0]        query_end,
	input  logic [CB-1:0]        subject_length,
	input  logic [CB-1:0]        subject_start,
	input  logic [CB-1:0]        subject_end,
	input  logic [IB-1:0]        identity,
	input  logic [SB-1:0]        score,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 reverse_strand,
	output logic signed [WB-1:0] overhang_left,
	output logic signed [WB-1:0] overhang_right,
	output logic [WB-1:0]        overlap_length,
	output logic [7:0]           coverage
);

	logic [IB-1:0] min_identity_q;
	logic [7:0]    min_coverage_q;
	logic [20:0]   min_overlap_q;
	logic [19:0]   max_overhang_q;
	logic [SB-1:0] min_score_q;
	logic          wr_en;
	reg_idx_t      reg_idx;

	hit_t  hit;
	logic  prep_ready;
	logic  chain_valid [QB+1];
	logic  chain_ready [QB+1];
	cell_t chain_item  [QB+1];

	logic                 out_ready;
	logic                 out_valid_q;
	cell_t                fin;
	logic [7:0]           cov;
	logic                 pass;
	logic signed [CW-1:0] lim;

	// configuration port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_identity_q <= '0;
			min_coverage_q <= '0;
			min_overlap_q  <= 21'd20;
			max_overhang_q <= 20'd100000;
			min_score_q    <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MIN_IDENTITY: min_identity_q <= pwdata[IB-1:0];
				REG_MIN_COVERAGE: min_coverage_q <= pwdata[7:0];
				REG_MIN_OVERLAP:  min_overlap_q  <= pwdata[20:0];
				REG_MAX_OVERHANG: max_overhang_q <= pwdata[19:0];
				REG_MIN_SCORE:    min_score_q    <= pwdata[SB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_IDENTITY: prdata = 32'(min_identity_q);
			REG_MIN_COVERAGE: prdata = 32'(min_coverage_q);
			REG_MIN_OVERLAP:  prdata = 32'(min_overlap_q);
			REG_MAX_OVERHANG: prdata = 32'(max_overhang_q);
			REG_MIN_SCORE:    prdata = 32'(min_score_q);
			default:          prdata = '0;
		endcase
	end

	// front stages
	always_comb begin
		hit.query_length   = query_length;
		hit.query_start    = query_start;
		hit.query_end      = query_end;
		hit.subject_length = subject_length;
		hit.subject_start  = subject_start;
		hit.subject_end    = subject_end;
		hit.identity       = identity;
		hit.score          = score;
	end

	ahf_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_valid),
		.up_ready   (prep_ready),
		.up_hit     (hit),
		.down_ready (chain_ready[0]),
		.down_valid (chain_valid[0]),
		.down_item  (chain_item[0])
	);

	assign in_stall = !prep_ready;

	// division cells, most significant quotient bit first
	for (genvar i = 0; i < QB; i++) begin : g_cell
		ahf_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (chain_valid[i]),
			.up_ready   (chain_ready[i]),
			.up_item    (chain_item[i]),
			.down_ready (chain_ready[i+1]),
			.down_valid (chain_valid[i+1]),
			.down_item  (chain_item[i+1])
		);
	end

	// verdict and output register
	assign out_ready       = !out_valid_q || !out_stall;
	assign chain_ready[QB] = out_ready;
	assign fin             = chain_item[QB];

	always_comb begin
		cov  = fin.quo[QB-1] ? 8'hFF : fin.quo[7:0];
		lim  = $signed(CW'(max_overhang_q));
		pass = (cov >= min_coverage_q) && (fin.ident >= min_identity_q) &&
			(CW'(fin.overlap) >= CW'(min_overlap_q)) && (fin.score >= min_score_q) &&
			(CW'(fin.left) <= lim) && (CW'(fin.right) <= lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= chain_valid[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && chain_valid[QB]) begin
			if (fin.bad) begin
				status         <= ST_INVALID;
				reverse_strand <= 1'b0;
				overhang_left  <= '0;
				overhang_right <= '0;
				overlap_length <= '0;
				coverage       <= '0;
			end else begin
				status         <= pass ? ST_PASS : ST_REJECT;
				reverse_strand <= fin.minus;
				overhang_left  <= fin.left;
				overhang_right <= fin.right;
				overlap_length <= fin.overlap;
				coverage       <= cov;
			end
		end
	end

	assign out_valid = out_valid_q;

	// an empty output register lets the whole chain move
	`AHF_ASSERT_IMP(a_empty_no_stall, !out_valid_q, !in_stall, "input stalled with empty output")
	`AHF_ASSERT_IMP(a_invalid_zero, out_valid_q && (status == ST_INVALID),
		!reverse_strand && (overlap_length == '0) && (coverage == '0) &&
		(overhang_left == '0) && (overhang_right == '0), "invalid word carries data")
	`AHF_ASSERT_IMP(a_pass_thresholds, out_valid_q && (status == ST_PASS),
		(coverage >= min_coverage_q) && (CW'(overlap_length) >= CW'(min_overlap_q)) &&
		(CW'(overhang_left) <= lim) && (CW'(overhang_right) <= lim),
		"passing word misses a threshold")
	`AHF_ASSERT(a_status_code, !out_valid_q || (status == ST_PASS) || (status == ST_REJECT) || (status == ST_INVALID), "undefined status code")
	`AHF_ASSERT_NEXT(a_taken_refill, out_valid_q && !out_stall && !chain_valid[QB],
		!out_valid_q, "output word repeated")

endmodule

`default_nettype wire

FILE: rtl/ahf_prep.sv
// ahf_prep: two front stages, end ordering then overhangs, overlap and dividend
// depends on ahf_pkg
`default_nettype none

module ahf_prep import ahf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  hit_t  up_hit,
	input  logic  down_ready,
	output logic  down_valid,
	output cell_t down_item
);

	logic  v_s1, v_s2;
	logic  ready_s1, ready_s2;
	logic  q_swap, s_swap;
	ord_t  ord_d, ord_s1;
	cell_t item_d, item_s2;

	logic signed [WB-1:0] q_lo_m1, s_lo_m1, qlen_m_hi, slen_m_hi;
	logic [CB-1:0] span_max, span_sel, den;

	assign ready_s2 = !v_s2 || down_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_comb begin
		q_swap = up_hit.query_start > up_hit.query_end;
		s_swap = up_hit.subject_start > up_hit.subject_end;
		ord_d.bad = (up_hit.query_start == up_hit.query_end) ||
			(up_hit.subject_start == up_hit.subject_end) ||
			(up_hit.query_length == '0) || (up_hit.subject_length == '0);
		ord_d.minus = q_swap ^ s_swap;
		ord_d.qlen = up_hit.query_length;
		ord_d.slen = up_hit.subject_length;
		ord_d.q_lo = q_swap ? up_hit.query_end : up_hit.query_start;
		ord_d.q_hi = q_swap ? up_hit.query_start : up_hit.query_end;
		ord_d.s_lo = s_swap ? up_hit.subject_end : up_hit.subject_start;
		ord_d.s_hi = s_swap ? up_hit.subject_start : up_hit.subject_end;
		ord_d.span_q = q_swap ? (up_hit.query_start - up_hit.query_end) :
			(up_hit.query_end - up_hit.query_start);
		ord_d.span_s = s_swap ? (up_hit.subject_start - up_hit.subject_end) :
			(up_hit.subject_end - up_hit.subject_start);
		ord_d.ident = up_hit.identity;
		ord_d.score = up_hit.score;
	end

	always_comb begin
		q_lo_m1   = $signed({1'b0, ord_s1.q_lo}) - $signed(W_ONE);
		s_lo_m1   = $signed({1'b0, ord_s1.s_lo}) - $signed(W_ONE);
		qlen_m_hi = $signed({1'b0, ord_s1.qlen}) - $signed({1'b0, ord_s1.q_hi});
		slen_m_hi = $signed({1'b0, ord_s1.slen}) - $signed({1'b0, ord_s1.s_hi});
		span_max  = (ord_s1.span_q > ord_s1.span_s) ? ord_s1.span_q : ord_s1.span_s;
		// query is the shorter one only when strictly shorter
		if (ord_s1.slen > ord_s1.qlen) begin
			span_sel = ord_s1.span_q;
			den      = ord_s1.qlen;
		end else begin
			span_sel = ord_s1.span_s;
			den      = ord_s1.slen;
		end
		item_d.bad   = ord_s1.bad;
		item_d.minus = ord_s1.minus;
		if (ord_s1.minus) begin
			item_d.right = smin(q_lo_m1, slen_m_hi);
			item_d.left  = smin(s_lo_m1, qlen_m_hi);
		end else begin
			item_d.right = smin(slen_m_hi, qlen_m_hi);
			item_d.left  = smin(s_lo_m1, q_lo_m1);
		end
		item_d.overlap = {1'b0, span_max} + W_ONE;
		item_d.ident   = ord_s1.ident;
		item_d.score   = ord_s1.score;
		item_d.rem     = NB'(span_sel) * HUNDRED;
		item_d.dsh     = {den, 8'b0};
		item_d.quo     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= up_valid;
			if (ready_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) ord_s1 <= ord_d;
		if (ready_s2 && v_s1) item_s2 <= item_d;
	end

	assign down_valid = v_s2;
	assign down_item  = item_s2;

endmodule

`default_nettype wire

FILE: rtl/ahf_div_cell.sv
// ahf_div_cell: one restoring division step on the coverage dividend
// depends on ahf_pkg
`default_nettype none

module ahf_div_cell import ahf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  cell_t up_item,
	input  logic  down_ready,
	output logic  down_valid,
	output cell_t down_item
);

	logic  v_q;
	logic  ge;
	cell_t nxt;
	cell_t item_q;

	assign up_ready = !v_q || down_ready;

	always_comb begin
		nxt = up_item;
		ge  = {1'b0, up_item.rem} >= up_item.dsh;
		if (ge) nxt.rem = NB'({1'b0, up_item.rem} - up_item.dsh);
		nxt.quo = {up_item.quo[QB-2:0], ge};
		nxt.dsh = up_item.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) item_q <= nxt;
	end

	assign down_valid = v_q;
	assign down_item  = item_q;

endmodule

`default_nettype wire
